// ===== sv/energy_vad_hangover_segmenter_core_assert.svh =====
// Assertion macros used by the voice activity detector's detect module
`ifndef ENERGY_VAD_HANGOVER_SEGMENTER_CORE_ASSERT_SVH
`define ENERGY_VAD_HANGOVER_SEGMENTER_CORE_ASSERT_SVH

// Implication in the same cycle, held off during reset
`define EVHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, held off during reset
`define EVHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/evhs_pkg.sv =====
// Types and constants of the energy voice activity detector
package evhs_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SQ_W      = 2 * SAMPLE_W - 1;
  localparam int SUM_W     = 41;
  localparam int FS_W      = 11;
  localparam int RUN_W     = 16;
  localparam int POS_W     = 24;
  localparam int MAX_FRAME = 1024;
  localparam int CNT_W     = $clog2(MAX_FRAME);
  localparam int EFS_W     = CNT_W + 1;
  localparam int DET_W     = 2;
  localparam int CFG_IDX_W = 4;

  localparam logic [SUM_W-1:0] THRESHOLD_RST = '0;
  localparam logic [FS_W-1:0]  FRAME_SIZE_RST = FS_W'(480);
  localparam logic [RUN_W-1:0] MIN_SPEECH_RST = RUN_W'(3);
  localparam logic [RUN_W-1:0] MIN_SILENCE_RST = RUN_W'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 4'd0,
    REG_FRAME_SIZE  = 4'd1,
    REG_MIN_SPEECH  = 4'd2,
    REG_MIN_SILENCE = 4'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_SILENCE  = 3'b001,
    ST_SPEECH   = 3'b010,
    ST_HANGOVER = 3'b100
  } vad_state_t;

  localparam logic [DET_W-1:0] DET_SILENCE  = 2'd0;
  localparam logic [DET_W-1:0] DET_SPEECH   = 2'd1;
  localparam logic [DET_W-1:0] DET_HANGOVER = 2'd2;

  typedef struct packed {
    logic [SUM_W-1:0] threshold;
    logic [EFS_W-1:0] frame_len;
    logic [RUN_W-1:0] min_speech;
    logic [RUN_W-1:0] min_silence;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [SQ_W-1:0] sq;
    logic            first;
    logic            last;
  } item_t;

  typedef struct packed {
    logic             frame_complete;
    logic             is_speech;
    logic [DET_W-1:0] detector_state;
    logic             segment_opened;
    logic             segment_closed;
    logic [POS_W-1:0] segment_begin_pos;
    logic [POS_W-1:0] segment_end_pos;
  } result_t;

endpackage

// ===== sv/evhs_ifs.sv =====
// Channel interfaces: sample input, result output and register write port
interface evhs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [evhs_pkg::SAMPLE_W-1:0]  sample;
  logic                                  first;
  logic                                  last;
  modport source (output valid, sample, first, last, input ready);
  modport sink (input valid, sample, first, last, output ready);
endinterface

interface evhs_out_if;
  logic                             valid;
  logic                             ready;
  logic                             frame_complete;
  logic                             is_speech;
  logic [evhs_pkg::DET_W-1:0]       detector_state;
  logic                             segment_opened;
  logic                             segment_closed;
  logic [evhs_pkg::POS_W-1:0]       segment_begin_pos;
  logic [evhs_pkg::POS_W-1:0]       segment_end_pos;
  modport source (output valid, frame_complete, is_speech, detector_state,
                  segment_opened, segment_closed, segment_begin_pos,
                  segment_end_pos, input ready);
  modport sink (input valid, frame_complete, is_speech, detector_state,
                segment_opened, segment_closed, segment_begin_pos,
                segment_end_pos, output ready);
endinterface

interface evhs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [evhs_pkg::CFG_IDX_W-1:0]   index;
  logic [evhs_pkg::SUM_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/evhs_cfg_regs.sv =====
// Configuration registers, with the frame length clamped to its legal range
module evhs_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  evhs_cfg_if.sink         cfg_ch,
  output evhs_pkg::cfg_t   cfg
);

  logic [evhs_pkg::SUM_W-1:0] threshold_r;
  logic [evhs_pkg::FS_W-1:0]  frame_size_r;
  logic [evhs_pkg::RUN_W-1:0] min_speech_r;
  logic [evhs_pkg::RUN_W-1:0] min_silence_r;
  logic [evhs_pkg::EFS_W-1:0] frame_len;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= evhs_pkg::THRESHOLD_RST;
      frame_size_r  <= evhs_pkg::FRAME_SIZE_RST;
      min_speech_r  <= evhs_pkg::MIN_SPEECH_RST;
      min_silence_r <= evhs_pkg::MIN_SILENCE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        evhs_pkg::REG_THRESHOLD:   threshold_r   <= cfg_ch.data;
        evhs_pkg::REG_FRAME_SIZE:  frame_size_r  <= cfg_ch.data[evhs_pkg::FS_W-1:0];
        evhs_pkg::REG_MIN_SPEECH:  min_speech_r  <= cfg_ch.data[evhs_pkg::RUN_W-1:0];
        evhs_pkg::REG_MIN_SILENCE: min_silence_r <= cfg_ch.data[evhs_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the largest frame acts as the largest
  always_comb begin
    if (frame_size_r == '0) begin
      frame_len = evhs_pkg::EFS_W'(1);
    end else if (32'(frame_size_r) > evhs_pkg::MAX_FRAME) begin
      frame_len = evhs_pkg::EFS_W'(evhs_pkg::MAX_FRAME);
    end else begin
      frame_len = evhs_pkg::EFS_W'(frame_size_r);
    end
  end

  assign cfg.threshold   = threshold_r;
  assign cfg.frame_len   = frame_len;
  assign cfg.min_speech  = min_speech_r;
  assign cfg.min_silence = min_silence_r;

endmodule

// ===== sv/evhs_frontend.sv =====
// Input register: takes an item and stores the square of its sample
module evhs_frontend (
  input  logic              clk,
  input  logic              rst_n,
  evhs_in_if.sink           in_ch,
  input  logic              advance,
  output evhs_pkg::item_t   item
);

  logic                               valid_r;
  logic [evhs_pkg::SQ_W-1:0]          sq_r;
  logic                               first_r;
  logic                               last_r;
  logic signed [2*evhs_pkg::SAMPLE_W-1:0] prod;
  logic                               in_fire;

  assign in_ch.ready = !valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign prod        = in_ch.sample * in_ch.sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_fire) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sq_r    <= prod[evhs_pkg::SQ_W-1:0];
      first_r <= in_ch.first;
      last_r  <= in_ch.last;
    end
  end

  assign item.valid = valid_r;
  assign item.sq    = sq_r;
  assign item.first = first_r;
  assign item.last  = last_r;

endmodule

// ===== sv/evhs_detect.sv =====
// Frame energy accumulation, detector state machine, segment tracking, result register
module evhs_detect (
  input  logic              clk,
  input  logic              rst_n,
  input  evhs_pkg::cfg_t    cfg,
  input  evhs_pkg::item_t   item,
  input  logic              out_ready,
  output logic              advance,
  output logic              out_valid,
  output evhs_pkg::result_t result
);

  `include "energy_vad_hangover_segmenter_core_assert.svh"

  // detector state
  logic [evhs_pkg::SUM_W-1:0]  sum_r, sum_nxt, sum_b, sum_acc;
  logic [evhs_pkg::SUM_W:0]    sum_ext;
  logic [evhs_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, cnt_b;
  logic [evhs_pkg::EFS_W-1:0]  cnt_inc;
  evhs_pkg::vad_state_t        st_r, st_nxt, st_b;
  logic [evhs_pkg::RUN_W-1:0]  sr_r, sr_nxt, sr_b;
  logic [evhs_pkg::RUN_W-1:0]  hr_r, hr_nxt, hr_b, hr_inc;
  logic                        inseg_r, inseg_nxt, inseg_b;
  logic [evhs_pkg::POS_W-1:0]  segst_r, segst_nxt, segst_b;
  logic [evhs_pkg::POS_W-1:0]  pos_r, pos_nxt, pos_b, pos_inc;
  logic [evhs_pkg::POS_W-1:0]  fbeg, endp;
  logic                        fdone, loud, speech, opened, closed, produce, consume;

  // result register
  logic                        out_valid_r;
  evhs_pkg::result_t           res_r, res_nxt;

  assign advance = !out_valid_r || out_ready;
  assign consume = item.valid && advance;

  always_comb begin
    // a first mark clears everything before this sample counts
    if (item.first) begin
      sum_b   = '0;
      cnt_b   = '0;
      st_b    = evhs_pkg::ST_SILENCE;
      sr_b    = '0;
      hr_b    = '0;
      inseg_b = 1'b0;
      segst_b = '0;
      pos_b   = '0;
    end else begin
      sum_b   = sum_r;
      cnt_b   = cnt_r;
      st_b    = st_r;
      sr_b    = sr_r;
      hr_b    = hr_r;
      inseg_b = inseg_r;
      segst_b = segst_r;
      pos_b   = pos_r;
    end

    sum_ext = {1'b0, sum_b} + (evhs_pkg::SUM_W + 1)'(item.sq);
    sum_acc = sum_ext[evhs_pkg::SUM_W] ? '1 : sum_ext[evhs_pkg::SUM_W-1:0];
    pos_inc = (pos_b != '1) ? pos_b + 1'b1 : pos_b;
    cnt_inc = {1'b0, cnt_b} + 1'b1;
    fdone   = cnt_inc >= cfg.frame_len;
    fbeg    = (pos_inc > evhs_pkg::POS_W'(cnt_inc)) ?
              pos_inc - evhs_pkg::POS_W'(cnt_inc) : '0;
    loud    = sum_acc > cfg.threshold;
    hr_inc  = (hr_b != '1) ? hr_b + 1'b1 : hr_b;

    st_nxt = st_b;
    sr_nxt = sr_b;
    hr_nxt = hr_b;
    if (fdone) begin
      if (loud) begin
        hr_nxt = '0;
        sr_nxt = (sr_b != '1) ? sr_b + 1'b1 : sr_b;
        st_nxt = evhs_pkg::ST_SPEECH;
      end else begin
        case (st_b)
          evhs_pkg::ST_SPEECH: begin
            if (sr_b >= cfg.min_speech) begin
              st_nxt = evhs_pkg::ST_HANGOVER;
              hr_nxt = evhs_pkg::RUN_W'(1);
            end else begin
              st_nxt = evhs_pkg::ST_SILENCE;
              sr_nxt = '0;
            end
          end
          evhs_pkg::ST_HANGOVER: begin
            hr_nxt = hr_inc;
            if (hr_inc >= cfg.min_silence) begin
              st_nxt = evhs_pkg::ST_SILENCE;
              sr_nxt = '0;
              hr_nxt = '0;
            end
          end
          default: ;
        endcase
      end
    end
    speech = st_nxt != evhs_pkg::ST_SILENCE;

    inseg_nxt = inseg_b;
    segst_nxt = segst_b;
    opened    = 1'b0;
    closed    = 1'b0;
    endp      = '0;
    if (fdone) begin
      if (speech && !inseg_b) begin
        inseg_nxt = 1'b1;
        segst_nxt = fbeg;
        opened    = 1'b1;
      end else if (!speech && inseg_b) begin
        inseg_nxt = 1'b0;
        closed    = 1'b1;
        endp      = fbeg;
      end
    end
    sum_nxt = fdone ? '0 : sum_acc;
    cnt_nxt = fdone ? '0 : cnt_inc[evhs_pkg::CNT_W-1:0];
    pos_nxt = pos_inc;

    // end of buffer: close at the buffer length, drop the partial frame
    if (item.last) begin
      if (inseg_nxt) begin
        inseg_nxt = 1'b0;
        closed    = 1'b1;
        endp      = pos_inc;
      end
      sum_nxt = '0;
      cnt_nxt = '0;
      pos_nxt = '0;
    end

    produce = fdone || closed;

    res_nxt.frame_complete    = fdone;
    res_nxt.is_speech         = speech;
    case (st_nxt)
      evhs_pkg::ST_SPEECH:   res_nxt.detector_state = evhs_pkg::DET_SPEECH;
      evhs_pkg::ST_HANGOVER: res_nxt.detector_state = evhs_pkg::DET_HANGOVER;
      default:               res_nxt.detector_state = evhs_pkg::DET_SILENCE;
    endcase
    res_nxt.segment_opened    = opened;
    res_nxt.segment_closed    = closed;
    res_nxt.segment_begin_pos = (inseg_nxt || closed) ? segst_nxt : '0;
    res_nxt.segment_end_pos   = endp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      cnt_r   <= '0;
      st_r    <= evhs_pkg::ST_SILENCE;
      sr_r    <= '0;
      hr_r    <= '0;
      inseg_r <= 1'b0;
      segst_r <= '0;
      pos_r   <= '0;
    end else if (consume) begin
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      st_r    <= st_nxt;
      sr_r    <= sr_nxt;
      hr_r    <= hr_nxt;
      inseg_r <= inseg_nxt;
      segst_r <= segst_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= consume && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && produce) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

  `EVHS_ASSERT_NOW(a_silence_no_segment, st_r == evhs_pkg::ST_SILENCE, !inseg_r,
    "segment open while detector is silent")
  `EVHS_ASSERT_NOW(a_hangover_run, st_r == evhs_pkg::ST_HANGOVER, hr_r != '0,
    "hangover with empty silence run")
  `EVHS_ASSERT_NOW(a_result_cause, out_valid_r,
    res_r.frame_complete || res_r.segment_closed, "result without frame end or close")
  `EVHS_ASSERT_NOW(a_open_is_speech, out_valid_r && res_r.segment_opened,
    res_r.is_speech && res_r.frame_complete, "segment opened outside a speech frame")
  `EVHS_ASSERT_NEXT(a_no_result_idle, !item.valid && out_valid_r && out_ready,
    !out_valid_r, "result appeared without an item")

endmodule

// ===== sv/energy_vad_hangover_segmenter_core.sv =====
// Top level of the energy voice activity detector with hangover and segmenter
// One Q1.15 sample is taken per item and one item can be taken every clock cycle;
// an item passes an input register (where its square is formed) and then one
// stage that accumulates frame energy, steps the silence/speech/hangover machine
// and tracks segment positions, so its result is registered as the item leaves the
// input register. A result is given only when a frame completes or a segment closes.
// The rate is set by the single energy accumulate and threshold compare per item.
// While a result waits untaken, the item in the input register cannot move on, so
// the input side stalls once that register is full, whether or not the waiting
// item gives a result. The user must write registers through the configuration port
// only while no item is in flight; the block itself does not enforce it.
module energy_vad_hangover_segmenter_core (
  input  logic        clk,
  input  logic        rst_n,
  evhs_in_if.sink     in_ch,
  evhs_out_if.source  out_ch,
  evhs_cfg_if.sink    cfg_ch
);

  evhs_pkg::cfg_t    cfg;
  evhs_pkg::item_t   item;
  evhs_pkg::result_t result;
  logic              advance;
  logic              out_valid;

  evhs_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  evhs_frontend u_frontend (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .item    (item)
  );

  evhs_detect u_detect (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item      (item),
    .out_ready (out_ch.ready),
    .advance   (advance),
    .out_valid (out_valid),
    .result    (result)
  );

  assign out_ch.valid             = out_valid;
  assign out_ch.frame_complete    = result.frame_complete;
  assign out_ch.is_speech         = result.is_speech;
  assign out_ch.detector_state    = result.detector_state;
  assign out_ch.segment_opened    = result.segment_opened;
  assign out_ch.segment_closed    = result.segment_closed;
  assign out_ch.segment_begin_pos = result.segment_begin_pos;
  assign out_ch.segment_end_pos   = result.segment_end_pos;

endmodule

// ===== tb/tb_energy_vad_hangover_segmenter_core.sv =====
// Self-checking testbench for the energy voice activity detector and segmenter
module tb_energy_vad_hangover_segmenter_core;

  localparam int HALF_PERIOD = 10;
  localparam int SETTLE_CYCLES = 6;
  localparam longint LIMIT_TIME = 64'd6_000_000;
  localparam logic [evhs_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED = '1;
  localparam logic [evhs_pkg::POS_W-1:0] POS_LIMIT = '1;
  localparam logic [evhs_pkg::SUM_W-1:0] SUM_LIMIT = '1;
  localparam logic [evhs_pkg::RUN_W-1:0] RUN_LIMIT = '1;

  // Predicts detector results per sample and holds the ones still owed by the block
  class segment_tracker;
    logic [evhs_pkg::SUM_W-1:0] threshold = evhs_pkg::THRESHOLD_RST;
    logic [evhs_pkg::FS_W-1:0]  frame_size = evhs_pkg::FRAME_SIZE_RST;
    logic [evhs_pkg::RUN_W-1:0] min_speech = evhs_pkg::MIN_SPEECH_RST;
    logic [evhs_pkg::RUN_W-1:0] min_silence = evhs_pkg::MIN_SILENCE_RST;
    logic [evhs_pkg::SUM_W-1:0] energy;
    int unsigned                fill;
    evhs_pkg::vad_state_t       state;
    logic [evhs_pkg::RUN_W-1:0] speech_run;
    logic [evhs_pkg::RUN_W-1:0] quiet_run;
    bit                         seg_open;
    logic [evhs_pkg::POS_W-1:0] seg_origin;
    logic [evhs_pkg::POS_W-1:0] position;
    evhs_pkg::result_t          reports_due[$];
    int unsigned                errors, samples, reports, frames, opened, closed, writes;

    function new();
      clear_buffer();
    endfunction

    static function int unsigned span_of(logic [evhs_pkg::FS_W-1:0] fs);
      if (fs == 0) return 1;
      if (fs > evhs_pkg::MAX_FRAME) return evhs_pkg::MAX_FRAME;
      return fs;
    endfunction

    function void clear_buffer();
      energy = '0;
      fill = 0;
      state = evhs_pkg::ST_SILENCE;
      speech_run = '0;
      quiet_run = '0;
      seg_open = 1'b0;
      seg_origin = '0;
      position = '0;
    endfunction

    function void write_reg(logic [evhs_pkg::CFG_IDX_W-1:0] idx,
                            logic [evhs_pkg::SUM_W-1:0] data);
      writes++;
      case (idx)
        evhs_pkg::REG_THRESHOLD:   threshold = data;
        evhs_pkg::REG_FRAME_SIZE:  frame_size = data[evhs_pkg::FS_W-1:0];
        evhs_pkg::REG_MIN_SPEECH:  min_speech = data[evhs_pkg::RUN_W-1:0];
        evhs_pkg::REG_MIN_SILENCE: min_silence = data[evhs_pkg::RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function void step_detector(bit loud);
      if (loud) begin
        quiet_run = '0;
        if (speech_run != RUN_LIMIT) speech_run++;
        state = evhs_pkg::ST_SPEECH;
      end else if (state == evhs_pkg::ST_SPEECH) begin
        if (speech_run >= min_speech) begin
          state = evhs_pkg::ST_HANGOVER;
          quiet_run = 1;
        end else begin
          state = evhs_pkg::ST_SILENCE;
          speech_run = '0;
        end
      end else if (state == evhs_pkg::ST_HANGOVER) begin
        if (quiet_run != RUN_LIMIT) quiet_run++;
        if (quiet_run >= min_silence) begin
          state = evhs_pkg::ST_SILENCE;
          speech_run = '0;
          quiet_run = '0;
        end
      end
    endfunction

    function void take_sample(logic signed [evhs_pkg::SAMPLE_W-1:0] pcm, bit first, bit last);
      int unsigned                span;
      longint                     pv;
      logic [evhs_pkg::SUM_W:0]   acc;
      logic [evhs_pkg::POS_W-1:0] fbeg;
      logic [evhs_pkg::POS_W-1:0] endp;
      bit                         fdone, opened_now, closed_now;
      evhs_pkg::result_t          r;
      span = span_of(frame_size);
      fdone = 1'b0;
      opened_now = 1'b0;
      closed_now = 1'b0;
      endp = '0;
      samples++;
      if (first) clear_buffer();
      pv = pcm;
      acc = {1'b0, energy} + (evhs_pkg::SUM_W + 1)'(pv * pv);
      energy = acc[evhs_pkg::SUM_W] ? SUM_LIMIT : acc[evhs_pkg::SUM_W-1:0];
      if (position != POS_LIMIT) position++;
      fill++;
      if (fill >= span) begin
        // frame begin uses the real count, which matters if the size shrank mid-frame
        fbeg = (position > fill) ? evhs_pkg::POS_W'(position - fill) : '0;
        fdone = 1'b1;
        step_detector(energy > threshold);
        if (state != evhs_pkg::ST_SILENCE && !seg_open) begin
          seg_open = 1'b1;
          seg_origin = fbeg;
          opened_now = 1'b1;
        end else if (state == evhs_pkg::ST_SILENCE && seg_open) begin
          seg_open = 1'b0;
          closed_now = 1'b1;
          endp = fbeg;
        end
        energy = '0;
        fill = 0;
      end
      if (last) begin
        if (seg_open) begin
          seg_open = 1'b0;
          closed_now = 1'b1;
          endp = position;
        end
        energy = '0;
        fill = 0;
        position = '0;
      end
      if (!fdone && !closed_now) return;
      r.frame_complete = fdone;
      r.is_speech = (state != evhs_pkg::ST_SILENCE);
      case (state)
        evhs_pkg::ST_SPEECH:   r.detector_state = evhs_pkg::DET_SPEECH;
        evhs_pkg::ST_HANGOVER: r.detector_state = evhs_pkg::DET_HANGOVER;
        default:               r.detector_state = evhs_pkg::DET_SILENCE;
      endcase
      r.segment_opened = opened_now;
      r.segment_closed = closed_now;
      r.segment_begin_pos = (seg_open || closed_now) ? seg_origin : '0;
      r.segment_end_pos = endp;
      reports_due = {reports_due, r};
      frames += fdone;
      opened += opened_now;
      closed += closed_now;
    endfunction

    function void compare_field(string name, logic [evhs_pkg::POS_W-1:0] want,
                                logic [evhs_pkg::POS_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(evhs_pkg::result_t got);
      evhs_pkg::result_t want;
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t: result with none awaited, expected nothing, actual %h", $time, got);
        return;
      end
      want = reports_due.pop_front();
      reports++;
      compare_field("frame_complete", want.frame_complete, got.frame_complete);
      compare_field("is_speech", want.is_speech, got.is_speech);
      compare_field("detector_state", want.detector_state, got.detector_state);
      compare_field("segment_opened", want.segment_opened, got.segment_opened);
      compare_field("segment_closed", want.segment_closed, got.segment_closed);
      compare_field("segment_begin_pos", want.segment_begin_pos, got.segment_begin_pos);
      compare_field("segment_end_pos", want.segment_end_pos, got.segment_end_pos);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   phase_count = 0;
  evhs_pkg::result_t seen;
  segment_tracker tracker = new();

  evhs_in_if  in_ch();
  evhs_out_if out_ch();
  evhs_cfg_if cfg_ch();

  energy_vad_hangover_segmenter_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) tracker.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) tracker.take_sample(in_ch.sample, in_ch.first, in_ch.last);
      if (out_ch.valid && out_ch.ready) begin
        seen = {out_ch.frame_complete, out_ch.is_speech, out_ch.detector_state,
                out_ch.segment_opened, out_ch.segment_closed,
                out_ch.segment_begin_pos, out_ch.segment_end_pos};
        tracker.check_result(seen);
      end
    end
  end

  task automatic send_pcm(input logic signed [evhs_pkg::SAMPLE_W-1:0] pcm, input bit first,
                          input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= pcm;
    in_ch.first <= first;
    in_ch.last <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // waits on the clock first so the monitor has noted the last accepted item
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.reports_due.size() != 0) @(posedge clk);
  endtask

  // items that give no result may still be in the pipe: allow for its depth
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [evhs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [evhs_pkg::SUM_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic configure(input logic [evhs_pkg::SUM_W-1:0] thr,
                           input logic [evhs_pkg::FS_W-1:0] fs,
                           input logic [evhs_pkg::RUN_W-1:0] msp,
                           input logic [evhs_pkg::RUN_W-1:0] msil);
    logic [evhs_pkg::SUM_W-1:0] junk;
    // unused upper data bits carry noise half the time
    junk = $urandom_range(1) ? evhs_pkg::SUM_W'({$urandom, $urandom}) : '0;
    write_reg(evhs_pkg::REG_THRESHOLD, thr);
    write_reg(evhs_pkg::REG_FRAME_SIZE, {junk[evhs_pkg::SUM_W-1:evhs_pkg::FS_W], fs});
    write_reg(evhs_pkg::REG_MIN_SPEECH, {junk[evhs_pkg::SUM_W-1:evhs_pkg::RUN_W], msp});
    write_reg(evhs_pkg::REG_MIN_SILENCE, {junk[evhs_pkg::SUM_W-1:evhs_pkg::RUN_W], msil});
    cfg_ch.valid <= 1'b0;
  endtask

  // threshold sits between frames of loud and quiet samples
  function automatic logic [evhs_pkg::SUM_W-1:0] quiet_ceiling(
      input logic [evhs_pkg::FS_W-1:0] fs);
    return evhs_pkg::SUM_W'(segment_tracker::span_of(fs)) << 24;
  endfunction

  task automatic run_phase(input logic [evhs_pkg::FS_W-1:0] fs,
                           input logic [evhs_pkg::RUN_W-1:0] msp,
                           input logic [evhs_pkg::RUN_W-1:0] msil,
                           input logic [evhs_pkg::SUM_W-1:0] thr,
                           input int unsigned n_items);
    int unsigned span, buf_left, frame_left, pause_at;
    bit loud, first, last;
    logic signed [evhs_pkg::SAMPLE_W-1:0] pcm;
    settle();
    configure(thr, fs, msp, msil);
    case (phase_count % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 53; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 53; end
      default: begin send_idle_pct = 15; stall_pct = 15; end
    endcase
    phase_count++;
    span = segment_tracker::span_of(fs);
    buf_left = 0;
    frame_left = 0;
    loud = 1'b0;
    pause_at = $urandom_range(n_items * 3 / 4, n_items / 4);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i == pause_at) hold_until_drained();
      first = (buf_left == 0);
      if (first) buf_left = span * $urandom_range(8, 1) + $urandom_range(span - 1, 0);
      if (frame_left == 0) begin
        frame_left = span;
        if ($urandom_range(99) < 30) loud = !loud;
      end
      last = (buf_left == 1);
      if ($urandom_range(99) < 8) begin
        // noise: any sample, buffer marks out of place
        pcm = evhs_pkg::SAMPLE_W'($urandom);
        first = ($urandom_range(9) == 0);
        last = ($urandom_range(9) == 0);
      end else if (loud) begin
        pcm = evhs_pkg::SAMPLE_W'($urandom_range(32767, 8192));
        if ($urandom_range(1)) pcm = -pcm;
        if ($urandom_range(49) == 0) pcm = 16'sh8000;
      end else begin
        pcm = evhs_pkg::SAMPLE_W'($urandom_range(2047, 0));
        if ($urandom_range(1)) pcm = -pcm;
      end
      send_pcm(pcm, first, last);
      buf_left--;
      frame_left--;
    end
  endtask

  initial begin
    #(LIMIT_TIME);
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.first = 1'b0;
    in_ch.last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = evhs_pkg::REG_THRESHOLD;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // zero frame size acts as one sample; full-scale negative is the only loud value
    configure((evhs_pkg::SUM_W'(1) << 30) - evhs_pkg::SUM_W'(1), '0,
              evhs_pkg::RUN_W'(2), evhs_pkg::RUN_W'(2));
    send_pcm(16'sh8000, 1'b1, 1'b0);
    send_pcm(16'sh7FFF, 1'b0, 1'b0);   // burst too short, dropped
    send_pcm(16'sh8000, 1'b0, 1'b0);
    send_pcm(16'sh8000, 1'b0, 1'b0);
    send_pcm(16'sh0000, 1'b0, 1'b0);   // into hangover
    send_pcm(16'sh0001, 1'b0, 1'b0);   // hangover runs out
    send_pcm(16'sh8000, 1'b0, 1'b1);   // opens, then closes at buffer end
    send_pcm(16'sh7FFF, 1'b1, 1'b1);   // one-sample buffers
    send_pcm(16'sh8000, 1'b1, 1'b1);
    send_pcm(16'sh5555, 1'b1, 1'b0);
    send_pcm(16'shAAAA, 1'b0, 1'b0);

    // partial frame left waiting, then the frame size shrinks under it
    settle();
    write_reg(evhs_pkg::REG_FRAME_SIZE, evhs_pkg::SUM_W'(4));
    cfg_ch.valid <= 1'b0;
    send_pcm(16'sh0000, 1'b0, 1'b0);
    send_pcm(16'sh0001, 1'b0, 1'b0);
    send_pcm(-16'sh0001, 1'b0, 1'b0);
    settle();
    write_reg(evhs_pkg::REG_FRAME_SIZE, evhs_pkg::SUM_W'(2));
    cfg_ch.valid <= 1'b0;
    send_pcm(16'sh0000, 1'b0, 1'b0);
    send_pcm(16'sh0000, 1'b0, 1'b1);   // last with nothing open: no result
    settle();
    write_reg(IDX_UNMAPPED, SUM_LIMIT);
    cfg_ch.valid <= 1'b0;

    run_phase(evhs_pkg::FS_W'(2), evhs_pkg::RUN_W'(1), evhs_pkg::RUN_W'(1),
              quiet_ceiling(evhs_pkg::FS_W'(2)), 150);
    run_phase(evhs_pkg::FS_W'(3), evhs_pkg::RUN_W'(2), evhs_pkg::RUN_W'(3),
              quiet_ceiling(evhs_pkg::FS_W'(3)), 150);
    run_phase('0, '0, '0, quiet_ceiling('0), 150);
    run_phase(evhs_pkg::FS_W'(5), evhs_pkg::RUN_W'(3), evhs_pkg::RUN_W'(4),
              quiet_ceiling(evhs_pkg::FS_W'(5)), 150);
    run_phase('1, evhs_pkg::RUN_W'(3), evhs_pkg::RUN_W'(7), '0, 1030);
    run_phase(evhs_pkg::FS_W'(4), RUN_LIMIT, RUN_LIMIT,
              quiet_ceiling(evhs_pkg::FS_W'(4)), 120);
    run_phase(evhs_pkg::FS_W'(6), evhs_pkg::RUN_W'(2), RUN_LIMIT, SUM_LIMIT, 100);
    run_phase(evhs_pkg::FS_W'(3), evhs_pkg::RUN_W'(1), evhs_pkg::RUN_W'(2),
              quiet_ceiling(evhs_pkg::FS_W'(3)), 120);
    settle();

    $display("Covered %0d samples in %0d random phases plus directed cases, %0d register writes",
             tracker.samples, phase_count, tracker.writes);
    $display("Checked %0d results: %0d frame ends, %0d segments opened, %0d closed",
             tracker.reports, tracker.frames, tracker.opened, tracker.closed);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
